// File: rtl/jkse_pkg.sv
// Shared types and constants for the JSON key string extractor.
package jkse_pkg;

    localparam int KEY_MAX     = 8;
    localparam int PAT_LEN_MAX = KEY_MAX + 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int CW_W        = 13;

    localparam logic [CW_W-1:0] SIZE_MAX_CHARS = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 2'd2;

    localparam logic [63:0]     RST_KEY_CHARS   = 64'd1701734764;
    localparam logic [3:0]      RST_KEY_LENGTH  = 4'd4;
    localparam logic [CW_W-1:0] RST_BUFFER_SIZE = 13'd4096;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_FOUND = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

    typedef struct packed {
        logic [63:0]     key_chars;
        logic [3:0]      key_length;
        logic [CW_W-1:0] buffer_size;
    } t_cfg;

    typedef struct packed {
        logic       is_end;
        logic [7:0] ch;
        logic       is_ws;
        logic       is_colon;
        logic       is_quote;
        logic       is_bslash;
        logic       is_hex;
        logic       is_u;
        logic [7:0] esc_ch;
    } t_item;

endpackage

// File: rtl/jkse_front.sv
// Front end: classifies each text byte and holds it in a two-entry queue.
module jkse_front
    import jkse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  [7:0] i_text_byte,
    input  logic  i_end_mark,
    output logic  o_in_stall,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_pop
);

    t_item      w_item;
    t_item      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_item           = '0;
        w_item.ch        = i_text_byte;
        w_item.is_end    = i_end_mark || (i_text_byte == 8'h00);
        w_item.is_ws     = (i_text_byte == 8'h20) ||
                           (i_text_byte >= 8'h09 && i_text_byte <= 8'h0D);
        w_item.is_colon  = (i_text_byte == CH_COLON);
        w_item.is_quote  = (i_text_byte == CH_QUOTE);
        w_item.is_bslash = (i_text_byte == CH_BSLASH);
        w_item.is_hex    = (i_text_byte >= 8'h30 && i_text_byte <= 8'h39) ||
                           (i_text_byte >= 8'h41 && i_text_byte <= 8'h46) ||
                           (i_text_byte >= 8'h61 && i_text_byte <= 8'h66);
        w_item.is_u      = (i_text_byte == 8'h75);
        unique case (i_text_byte)
            8'h62:   w_item.esc_ch = 8'h08;
            8'h66:   w_item.esc_ch = 8'h0C;
            8'h6E:   w_item.esc_ch = 8'h0A;
            8'h72:   w_item.esc_ch = 8'h0D;
            8'h74:   w_item.esc_ch = 8'h09;
            8'h75:   w_item.esc_ch = CH_QMARK;
            default: w_item.esc_ch = i_text_byte;
        endcase
    end

    assign o_in_stall = (r_count == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign w_pop      = o_q_valid && i_q_pop;
    assign o_q_item   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: rtl/jkse_back.sv
// Back end: key search, value decode and the registered result stage.
module jkse_back
    import jkse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_value_char
);

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_PRE_COLON,
        PH_POST_COLON,
        PH_VALUE,
        PH_ESCAPE,
        PH_HEX,
        PH_DONE
    } t_phase;

    t_phase          r_phase,  n_phase;
    logic [3:0]      r_match,  n_match;
    logic [2:0]      r_hex,    n_hex;
    logic [CW_W-1:0] r_cw,     n_cw;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_kind,   n_kind;
    logic [7:0]      r_char,   n_char;

    logic [7:0]      w_pat [PAT_LEN_MAX];
    logic [3:0]      w_klen;
    logic [3:0]      w_plen;
    logic [3:0]      w_m;
    logic [3:0]      w_fb;
    logic            w_direct;
    logic            w_full;
    logic [CW_W-1:0] w_cap;
    logic            w_pop;

    assign w_pop   = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = w_pop;

    // Key pattern: quote, key bytes, quote.
    always_comb begin
        int kidx;
        kidx   = 0;
        w_klen = (i_cfg.key_length > 4'(KEY_MAX)) ? 4'(KEY_MAX) : i_cfg.key_length;
        w_plen = w_klen + 4'd2;
        w_pat[0] = CH_QUOTE;
        for (int j = 1; j < PAT_LEN_MAX; j++) begin
            kidx = (j - 1 < KEY_MAX) ? j - 1 : 0;
            if (j == int'(w_klen) + 1 || j > KEY_MAX) begin
                w_pat[j] = CH_QUOTE;
            end else begin
                w_pat[j] = i_cfg.key_chars[8*kidx +: 8];
            end
        end
    end

    // Match step with fallback to the longest prefix that still matches.
    always_comb begin
        logic ok;
        ok       = 1'b0;
        w_m      = (r_match >= w_plen) ? 4'd0 : r_match;
        w_direct = (w_pat[w_m] == i_q_item.ch);
        w_full   = w_direct && ((w_m + 4'd1) == w_plen);
        w_fb     = 4'd0;
        for (int mm = 1; mm < PAT_LEN_MAX; mm++) begin
            if (w_m == 4'(mm)) begin
                for (int kk = 1; kk <= mm; kk++) begin
                    ok = (w_pat[kk-1] == i_q_item.ch);
                    for (int ii = 0; ii < kk - 1; ii++) begin
                        if (w_pat[ii] != w_pat[mm-kk+1+ii]) begin
                            ok = 1'b0;
                        end
                    end
                    if (ok) begin
                        w_fb = 4'(kk);
                    end
                end
            end
        end
    end

    assign w_cap = (i_cfg.buffer_size > SIZE_MAX_CHARS) ? SIZE_MAX_CHARS : i_cfg.buffer_size;

    always_comb begin
        logic       res;
        logic       do_emit;
        logic       do_value;
        logic [7:0] ech;
        res      = 1'b0;
        do_emit  = 1'b0;
        do_value = 1'b0;
        ech      = i_q_item.ch;
        n_phase  = r_phase;
        n_match  = r_match;
        n_hex    = r_hex;
        n_cw     = r_cw;
        n_kind   = r_kind;
        n_char   = r_char;

        if (i_q_item.is_end) begin
            n_phase = PH_SEARCH;
            n_match = 4'd0;
            n_hex   = 3'd0;
            n_cw    = '0;
            if (r_phase != PH_DONE) begin
                res    = 1'b1;
                n_kind = KIND_FAIL;
                n_char = 8'h00;
            end
        end else begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (w_full) begin
                        n_phase = PH_PRE_COLON;
                        n_match = 4'd0;
                    end else if (w_direct) begin
                        n_match = w_m + 4'd1;
                    end else begin
                        n_match = w_fb;
                    end
                end
                PH_PRE_COLON, PH_POST_COLON: begin
                    if (i_q_item.is_ws) begin
                        n_phase = r_phase;
                    end else if (r_phase == PH_PRE_COLON && i_q_item.is_colon) begin
                        n_phase = PH_POST_COLON;
                    end else if (r_phase == PH_POST_COLON && i_q_item.is_quote) begin
                        n_phase = PH_VALUE;
                        n_cw    = '0;
                    end else begin
                        n_phase = PH_SEARCH;
                        n_match = i_q_item.is_quote ? 4'd1 : 4'd0;
                        n_hex   = 3'd0;
                        n_cw    = '0;
                    end
                end
                PH_VALUE: begin
                    do_value = 1'b1;
                end
                PH_ESCAPE: begin
                    ech     = i_q_item.esc_ch;
                    do_emit = 1'b1;
                    if (i_q_item.is_u) begin
                        n_phase = PH_HEX;
                        n_hex   = 3'd0;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
                PH_HEX: begin
                    if (r_hex < 3'd4 && i_q_item.is_hex) begin
                        n_hex = r_hex + 3'd1;
                    end else begin
                        n_hex    = 3'd0;
                        n_phase  = PH_VALUE;
                        do_value = 1'b1;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_SEARCH;
                    n_match = 4'd0;
                    n_hex   = 3'd0;
                    n_cw    = '0;
                end
            endcase

            if (do_value) begin
                if (i_q_item.is_quote) begin
                    n_phase = PH_DONE;
                    res     = 1'b1;
                    n_kind  = KIND_FOUND;
                    n_char  = 8'h00;
                end else if (i_q_item.is_bslash) begin
                    n_phase = PH_ESCAPE;
                end else begin
                    do_emit = 1'b1;
                end
            end

            if (do_emit) begin
                res = 1'b1;
                if (({1'b0, r_cw} + 14'd1) >= {1'b0, w_cap}) begin
                    n_phase = PH_DONE;
                    n_kind  = KIND_FAIL;
                    n_char  = 8'h00;
                end else begin
                    n_cw   = r_cw + 13'd1;
                    n_kind = KIND_CHAR;
                    n_char = ech;
                end
            end
        end

        if (w_pop) begin
            n_out_valid = res;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
            n_phase     = r_phase;
            n_match     = r_match;
            n_hex       = r_hex;
            n_cw        = r_cw;
            n_kind      = r_kind;
            n_char      = r_char;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_char <= n_char;
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_match     <= 4'd0;
            r_hex       <= 3'd0;
            r_cw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_match     <= n_match;
            r_hex       <= n_hex;
            r_cw        <= n_cw;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_value_char  = r_char;

    a_search_no_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEARCH) |-> (r_hex == 3'd0))
        else $error("hex count left over in search");

    a_hex_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex <= 3'd4)
        else $error("hex count beyond four");

    a_cw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cw < SIZE_MAX_CHARS)
        else $error("character count reached capacity limit");

    a_no_pop_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_q_pop)
        else $error("queue popped while result is held");

    a_kind_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KIND_CHAR) |-> (r_char == 8'h00))
        else $error("status item carries a character");

endmodule

// File: rtl/json_key_string_extractor_top.sv
// Top level of the JSON key string extractor: configuration registers and wiring.
//
// The block takes one text byte per cycle and, with the output side taking
// items, sustains one byte per cycle. An accepted byte lands in a two-entry
// queue, and its result, if any, is registered on the output register when the
// back end pops it. The input stalls only when that queue is full, which happens
// when the output side holds off. Each byte yields at most one item: a value
// character, found, or failed. Configuration is written by index: 0 key bytes,
// 1 key length, 2 buffer size.
module json_key_string_extractor_top
    import jkse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_end_mark,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_result_kind,
    output logic [7:0]            o_value_char
);

    t_cfg  r_cfg;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_chars   <= RST_KEY_CHARS;
            r_cfg.key_length  <= RST_KEY_LENGTH;
            r_cfg.buffer_size <= RST_BUFFER_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_CHARS:   r_cfg.key_chars   <= i_cfg_data;
                CFG_KEY_LENGTH:  r_cfg.key_length  <= i_cfg_data[3:0];
                CFG_BUFFER_SIZE: r_cfg.buffer_size <= i_cfg_data[CW_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    jkse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_text_byte (i_text_byte),
        .i_end_mark  (i_end_mark),
        .o_in_stall  (o_in_stall),
        .o_q_valid   (w_q_valid),
        .o_q_item    (w_q_item),
        .i_q_pop     (w_q_pop)
    );

    jkse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_value_char  (o_value_char)
    );

endmodule
